>>> design/ecmsc_pkg.sv
// Shared types, codes and the two-level chain program for the ECM stage-1 interpreter.
// Holds the opcode-to-macro table and the per-macro micro-op expansion.
// No dependencies.
package ecmsc_pkg;

  // ALU operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_RED = 3'd3;
  localparam logic [2:0] OP_CPY = 3'd4;

  // macro kinds
  localparam logic [1:0] K_ADD  = 2'd0;
  localparam logic [1:0] K_DBL  = 2'd1;
  localparam logic [1:0] K_CPY  = 2'd2;
  localparam logic [1:0] K_INIT = 2'd3;

  // points in the register file, two words each (x then z)
  localparam logic [2:0] PT_A  = 3'd0;
  localparam logic [2:0] PT_B  = 3'd1;
  localparam logic [2:0] PT_C  = 3'd2;
  localparam logic [2:0] PT_T  = 3'd3;
  localparam logic [2:0] PT_T2 = 3'd4;
  localparam logic [2:0] PT_R  = 3'd5;

  // operand sources: 0..15 register file, above that fixed sources
  localparam logic [4:0] SRC_U    = 5'd12;
  localparam logic [4:0] SRC_V    = 5'd13;
  localparam logic [4:0] SRC_W    = 5'd14;
  localparam logic [4:0] SRC_CB   = 5'd16;
  localparam logic [4:0] SRC_SX   = 5'd17;
  localparam logic [4:0] SRC_SZ   = 5'd18;
  localparam logic [4:0] SRC_ZERO = 5'd19;
  localparam logic [4:0] SRC_RAM_TOP = 5'd15;

  localparam logic [3:0] CMD_COUNT = 4'd13;   // opcodes 13..15 are illegal
  localparam logic [5:0] INIT_IDX  = 6'd42;
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_CURVE_B = 2'd1;
  localparam logic [1:0] REG_START_X = 2'd2;
  localparam logic [1:0] REG_START_Z = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] dst;
    logic [4:0] srca;
    logic [4:0] srcb;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] p;
    logic [2:0] q;
    logic [2:0] d;
    logic [2:0] dst;
    logic       fin;
  } mac_t;

  function automatic logic [4:0] sx(input logic [2:0] p);
    sx = {1'b0, p, 1'b0};
  endfunction

  function automatic logic [4:0] sz(input logic [2:0] p);
    sz = {1'b0, p, 1'b1};
  endfunction

  function automatic uop_t mk(input logic [2:0] op, input logic [4:0] d,
                              input logic [4:0] a, input logic [4:0] b, input logic l);
    uop_t u;
    u.op = op;
    u.dst = d[3:0];
    u.srca = a;
    u.srcb = b;
    u.last = l;
    mk = u;
  endfunction

  function automatic mac_t mm(input logic [1:0] k, input logic [2:0] p, input logic [2:0] q,
                              input logic [2:0] d, input logic [2:0] t, input logic f);
    mac_t m;
    m.kind = k;
    m.p = p;
    m.q = q;
    m.d = d;
    m.dst = t;
    m.fin = f;
    mm = m;
  endfunction

  // first macro of each opcode
  function automatic logic [5:0] op_start(input logic [3:0] cmd);
    logic [5:0] r;
    unique case (cmd)
      4'd0:    r = 6'd0;
      4'd1:    r = 6'd3;
      4'd2:    r = 6'd7;
      4'd3:    r = 6'd9;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd17;
      4'd7:    r = 6'd24;
      4'd8:    r = 6'd28;
      4'd9:    r = 6'd35;
      4'd10:   r = 6'd37;
      4'd11:   r = 6'd40;
      4'd12:   r = 6'd41;
      default: r = 6'd0;
    endcase
    op_start = r;
  endfunction

  // macro program: ADD is p+q with difference d, DBL doubles p, CPY copies p
  function automatic mac_t mac_rom(input logic [5:0] idx);
    mac_t m;
    unique case (idx)
      6'd0:  m = mm(K_CPY, PT_A,  PT_A,  PT_A, PT_R,  1'b0);   // swap A,B
      6'd1:  m = mm(K_CPY, PT_B,  PT_A,  PT_A, PT_A,  1'b0);
      6'd2:  m = mm(K_CPY, PT_R,  PT_A,  PT_A, PT_B,  1'b1);
      6'd3:  m = mm(K_ADD, PT_A,  PT_B,  PT_C, PT_T,  1'b0);
      6'd4:  m = mm(K_ADD, PT_T,  PT_A,  PT_B, PT_T2, 1'b0);
      6'd5:  m = mm(K_ADD, PT_B,  PT_T,  PT_A, PT_B,  1'b0);
      6'd6:  m = mm(K_CPY, PT_T2, PT_A,  PT_A, PT_A,  1'b1);
      6'd7:  m = mm(K_ADD, PT_A,  PT_B,  PT_C, PT_B,  1'b0);
      6'd8:  m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_A,  1'b1);
      6'd9:  m = mm(K_ADD, PT_B,  PT_A,  PT_C, PT_C,  1'b0);
      6'd10: m = mm(K_CPY, PT_B,  PT_A,  PT_A, PT_R,  1'b0);
      6'd11: m = mm(K_CPY, PT_C,  PT_A,  PT_A, PT_B,  1'b0);
      6'd12: m = mm(K_CPY, PT_R,  PT_A,  PT_A, PT_C,  1'b1);
      6'd13: m = mm(K_ADD, PT_B,  PT_A,  PT_C, PT_B,  1'b0);
      6'd14: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_A,  1'b1);
      6'd15: m = mm(K_ADD, PT_C,  PT_A,  PT_B, PT_C,  1'b0);
      6'd16: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_A,  1'b1);
      6'd17: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_T,  1'b0);
      6'd18: m = mm(K_ADD, PT_A,  PT_B,  PT_C, PT_T2, 1'b0);
      6'd19: m = mm(K_ADD, PT_T,  PT_A,  PT_A, PT_A,  1'b0);
      6'd20: m = mm(K_ADD, PT_T,  PT_T2, PT_C, PT_C,  1'b0);
      6'd21: m = mm(K_CPY, PT_B,  PT_A,  PT_A, PT_R,  1'b0);
      6'd22: m = mm(K_CPY, PT_C,  PT_A,  PT_A, PT_B,  1'b0);
      6'd23: m = mm(K_CPY, PT_R,  PT_A,  PT_A, PT_C,  1'b1);
      6'd24: m = mm(K_ADD, PT_A,  PT_B,  PT_C, PT_T,  1'b0);
      6'd25: m = mm(K_ADD, PT_T,  PT_A,  PT_B, PT_B,  1'b0);
      6'd26: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_T,  1'b0);
      6'd27: m = mm(K_ADD, PT_A,  PT_T,  PT_A, PT_A,  1'b1);
      6'd28: m = mm(K_ADD, PT_A,  PT_B,  PT_C, PT_T,  1'b0);
      6'd29: m = mm(K_ADD, PT_C,  PT_A,  PT_B, PT_C,  1'b0);
      6'd30: m = mm(K_CPY, PT_B,  PT_A,  PT_A, PT_R,  1'b0);
      6'd31: m = mm(K_CPY, PT_T,  PT_A,  PT_A, PT_B,  1'b0);
      6'd32: m = mm(K_CPY, PT_R,  PT_A,  PT_A, PT_T,  1'b0);
      6'd33: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_T,  1'b0);
      6'd34: m = mm(K_ADD, PT_A,  PT_T,  PT_A, PT_A,  1'b1);
      6'd35: m = mm(K_ADD, PT_C,  PT_B,  PT_A, PT_C,  1'b0);
      6'd36: m = mm(K_DBL, PT_B,  PT_A,  PT_A, PT_B,  1'b1);
      6'd37: m = mm(K_CPY, PT_A,  PT_A,  PT_A, PT_B,  1'b0);
      6'd38: m = mm(K_CPY, PT_A,  PT_A,  PT_A, PT_C,  1'b0);
      6'd39: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_A,  1'b1);
      6'd40: m = mm(K_ADD, PT_A,  PT_B,  PT_C, PT_A,  1'b1);
      6'd41: m = mm(K_DBL, PT_A,  PT_A,  PT_A, PT_A,  1'b1);
      default: m = mm(K_INIT, PT_A, PT_A,  PT_A, PT_A,  1'b1);
    endcase
    mac_rom = m;
  endfunction

  // expand one macro step into a micro-op; add and double results land in R, then get copied out
  function automatic uop_t uop_gen(input mac_t m, input logic [3:0] step);
    uop_t u;
    logic [4:0] dx;
    logic [4:0] dz;
    logic [4:0] rx;
    logic [4:0] rz;
    dx = sx(m.dst);
    dz = sz(m.dst);
    rx = sx(PT_R);
    rz = sz(PT_R);
    u = mk(OP_CPY, dx, sx(m.p), SRC_ZERO, 1'b1);
    unique case (m.kind)
      K_ADD: begin
        unique case (step)
          4'd0:  u = mk(OP_SUB, SRC_U, sx(m.p), sz(m.p), 1'b0);
          4'd1:  u = mk(OP_ADD, SRC_W, sx(m.q), sz(m.q), 1'b0);
          4'd2:  u = mk(OP_MUL, SRC_U, SRC_U, SRC_W, 1'b0);
          4'd3:  u = mk(OP_ADD, SRC_V, sx(m.p), sz(m.p), 1'b0);
          4'd4:  u = mk(OP_SUB, SRC_W, sx(m.q), sz(m.q), 1'b0);
          4'd5:  u = mk(OP_MUL, SRC_V, SRC_V, SRC_W, 1'b0);
          4'd6:  u = mk(OP_ADD, SRC_W, SRC_U, SRC_V, 1'b0);
          4'd7:  u = mk(OP_SUB, SRC_V, SRC_U, SRC_V, 1'b0);
          4'd8:  u = mk(OP_MUL, SRC_W, SRC_W, SRC_W, 1'b0);
          4'd9:  u = mk(OP_MUL, SRC_V, SRC_V, SRC_V, 1'b0);
          4'd10: u = mk(OP_MUL, rx, SRC_W, sz(m.d), 1'b0);
          4'd11: u = mk(OP_MUL, rz, sx(m.d), SRC_V, 1'b0);
          4'd12: u = mk(OP_CPY, dx, rx, SRC_ZERO, 1'b0);
          default: u = mk(OP_CPY, dz, rz, SRC_ZERO, 1'b1);
        endcase
      end
      K_DBL: begin
        unique case (step)
          4'd0:  u = mk(OP_ADD, SRC_U, sx(m.p), sz(m.p), 1'b0);
          4'd1:  u = mk(OP_SUB, SRC_V, sx(m.p), sz(m.p), 1'b0);
          4'd2:  u = mk(OP_MUL, SRC_U, SRC_U, SRC_U, 1'b0);
          4'd3:  u = mk(OP_MUL, SRC_V, SRC_V, SRC_V, 1'b0);
          4'd4:  u = mk(OP_MUL, rx, SRC_U, SRC_V, 1'b0);
          4'd5:  u = mk(OP_SUB, SRC_W, SRC_U, SRC_V, 1'b0);
          4'd6:  u = mk(OP_MUL, SRC_U, SRC_W, SRC_CB, 1'b0);
          4'd7:  u = mk(OP_ADD, SRC_U, SRC_U, SRC_V, 1'b0);
          4'd8:  u = mk(OP_MUL, rz, SRC_W, SRC_U, 1'b0);
          4'd9:  u = mk(OP_CPY, dx, rx, SRC_ZERO, 1'b0);
          default: u = mk(OP_CPY, dz, rz, SRC_ZERO, 1'b1);
        endcase
      end
      K_CPY: begin
        if (step == 4'd0) begin
          u = mk(OP_CPY, dx, sx(m.p), SRC_ZERO, 1'b0);
        end else begin
          u = mk(OP_CPY, dz, sz(m.p), SRC_ZERO, 1'b1);
        end
      end
      default: begin
        // run start: A from the start point, B, C and temporaries cleared
        priority if (step == 4'd0) begin
          u = mk(OP_RED, sx(PT_A), SRC_SX, SRC_ZERO, 1'b0);
        end else if (step == 4'd1) begin
          u = mk(OP_RED, sz(PT_A), SRC_SZ, SRC_ZERO, 1'b0);
        end else begin
          u = mk(OP_CPY, {1'b0, step}, SRC_ZERO, SRC_ZERO, step == 4'd9);
        end
      end
    endcase
    uop_gen = u;
  endfunction

endpackage

>>> design/ecmsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ecmsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ecmsc_alu.sv
// Bit-serial modular arithmetic unit: add, subtract, multiply, reduce, copy.
// Operands are reduced by restoring division one bit per cycle when not below
// the modulus. Depends on ecmsc_pkg.
module ecmsc_alu
  import ecmsc_pkg::*;
#(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [2:0]   op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_CHK  = 3'd1;
  localparam logic [2:0] A_RED  = 3'd2;
  localparam logic [2:0] A_OPER = 3'd3;
  localparam logic [2:0] A_MUL0 = 3'd4;
  localparam logic [2:0] A_MUL1 = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [W-1:0]  opa_r, opa_nxt;
  logic [W-1:0]  opb_r, opb_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          which_r, which_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  res_r, res_nxt;

  logic [W-1:0]  cur;
  logic [W:0]    t_red, t_dbl, t_add, s_add;
  logic          m_zero;

  assign m_zero = (m == '0);
  assign cur    = which_r ? opb_r : opa_r;
  assign t_red  = {rem_r, sh_r[W-1]};
  assign t_dbl  = {rem_r, 1'b0};
  assign t_add  = {1'b0, rem_r} + {1'b0, opa_r};
  assign s_add  = {1'b0, opa_r} + {1'b0, opb_r};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    which_nxt = which_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          op_nxt    = op;
          opa_nxt   = a;
          opb_nxt   = b;
          which_nxt = 1'b0;
          state_nxt = A_CHK;
        end
      end
      A_CHK: begin
        priority if (op_r == OP_CPY) begin
          res_nxt   = opa_r;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else if (m_zero || cur < m) begin
          if (m_zero) begin
            if (which_r) opb_nxt = '0;
            else         opa_nxt = '0;
          end
          if (!which_r && op_r != OP_RED) begin
            which_nxt = 1'b1;
          end else begin
            state_nxt = A_OPER;
          end
        end else begin
          rem_nxt   = '0;
          sh_nxt    = cur;
          cnt_nxt   = CNT_TOP;
          state_nxt = A_RED;
        end
      end
      A_RED: begin
        // remainder step: shift in one bit, subtract the modulus if it fits
        rem_nxt = (t_red >= {1'b0, m}) ? W'(t_red - {1'b0, m}) : t_red[W-1:0];
        sh_nxt  = {sh_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (which_r) opb_nxt = rem_nxt;
          else         opa_nxt = rem_nxt;
          state_nxt = A_CHK;
        end
      end
      A_OPER: begin
        state_nxt = A_IDLE;
        done_nxt  = 1'b1;
        unique case (op_r)
          OP_ADD: res_nxt = (s_add >= {1'b0, m}) ? W'(s_add - {1'b0, m}) : s_add[W-1:0];
          OP_SUB: res_nxt = (opa_r >= opb_r) ? (opa_r - opb_r) : (opa_r - opb_r + m);
          OP_MUL: begin
            done_nxt  = 1'b0;
            rem_nxt   = '0;
            sh_nxt    = opb_r;
            cnt_nxt   = CNT_TOP;
            state_nxt = A_MUL0;
          end
          default: res_nxt = opa_r;
        endcase
      end
      A_MUL0: begin
        rem_nxt   = (t_dbl >= {1'b0, m}) ? W'(t_dbl - {1'b0, m}) : t_dbl[W-1:0];
        state_nxt = A_MUL1;
      end
      A_MUL1: begin
        if (sh_r[W-1]) begin
          rem_nxt = (t_add >= {1'b0, m}) ? W'(t_add - {1'b0, m}) : t_add[W-1:0];
        end
        sh_nxt  = {sh_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_nxt   = rem_nxt;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else begin
          state_nxt = A_MUL0;
        end
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      which_r <= 1'b0;
      cnt_r   <= '0;
      op_r    <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      which_r <= which_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> design/ecm_stage1_chain_interpreter_core.sv
// ECM stage-1 addition-chain interpreter on a Montgomery curve (x:z form).
// Input stream: one chain opcode per transaction in in_tdata[3:0], in_tlast marks
// the final opcode of a run. The first opcode of a run loads A from start_x/start_z
// and clears B, C and the temporaries. After the last opcode one transaction goes
// out: out_tdata = {point_z, point_x}, out_tuser = bad_opcode.
// Configuration goes through the APB-style cfg_ port: modulus at 0x00, curve_b
// at 0x08, start_x at 0x10, start_z at 0x18; write only while the block is idle.
// One opcode at a time: in_tready is high only while the sequencer is idle.
// Every operation runs on one bit-serial modular ALU; any operand not already
// below the modulus is reduced first, except for a copy. A differential addition
// is 6 multiplies and a doubling 5; the swap is the shortest opcode and
// opcodes 6 and 8 the longest, and the first opcode of a run also carries
// the run-start load.
// Illegal opcodes 13..15 change no point and set bad_opcode for the run.
// Reset clears the sequencer, the run state and the output valid; the config
// registers return to modulus 3, curve_b 0, start_x 0, start_z 1.
// A stalled receiver holds the result; the next opcode is still accepted, and
// only a second result waits until the first has been taken.
module ecm_stage1_chain_interpreter_core
  import ecmsc_pkg::*;
#(
  parameter int RESIDUE_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [3:0] command, [7:4] zero
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,   // [63:0] point_x, [127:64] point_z
  output logic         out_tuser,   // [0] bad_opcode
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int W = RESIDUE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_RDA   = 3'd2;
  localparam logic [2:0] S_RDB   = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // configuration
  logic [63:0] mod_r, cb_r, sx_r, sz_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= 64'd3;
      cb_r  <= 64'd0;
      sx_r  <= 64'd0;
      sz_r  <= 64'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODULUS: mod_r <= cfg_pwdata;
        REG_CURVE_B: cb_r  <= cfg_pwdata;
        REG_START_X: sx_r  <= cfg_pwdata;
        default:     sz_r  <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODULUS: cfg_prdata = mod_r;
      REG_CURVE_B: cfg_prdata = cb_r;
      REG_START_X: cfg_prdata = sx_r;
      default:     cfg_prdata = sz_r;
    endcase
  end

  // sequencer state
  logic [2:0]   state_r, state_nxt;
  logic [5:0]   mpc_r, mpc_nxt;
  logic [3:0]   step_r, step_nxt;
  logic [3:0]   cmd_r, cmd_nxt;
  logic         last_r, last_nxt;
  logic         illegal_r, illegal_nxt;
  logic         init_r, init_nxt;
  logic         run_r, run_nxt;
  logic         err_r, err_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [W-1:0] ox_r, ox_nxt, oz_r, oz_nxt;
  logic         obad_r, obad_nxt;
  logic [W-1:0] ax_r, az_r;
  logic [W-1:0] opa_r, opa_nxt;

  mac_t         mac;
  uop_t         uop;
  logic [3:0]   raddr;
  logic [W-1:0] rdata;
  logic         we;
  logic         alu_start;
  logic         alu_done;
  logic [W-1:0] alu_res;
  logic [W-1:0] opb;
  logic         in_acc;
  logic         cmd_bad;

  assign mac = mac_rom(mpc_r);
  assign uop = uop_gen(mac, step_r);

  function automatic logic [W-1:0] src_val(input logic [4:0] src, input logic [W-1:0] rd,
                                           input logic [63:0] cb, input logic [63:0] x,
                                           input logic [63:0] z);
    logic [W-1:0] v;
    priority if (src <= SRC_RAM_TOP) v = rd;
    else if (src == SRC_CB)          v = cb[W-1:0];
    else if (src == SRC_SX)          v = x[W-1:0];
    else if (src == SRC_SZ)          v = z[W-1:0];
    else                             v = '0;
    src_val = v;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cmd_bad   = (in_tdata[3:0] >= CMD_COUNT);
  assign raddr     = (state_r == S_RDA) ? uop.srcb[3:0] : uop.srca[3:0];
  assign opb       = src_val(uop.srcb, rdata, cb_r, sx_r, sz_r);
  assign alu_start = (state_r == S_RDB);
  assign we        = (state_r == S_EXEC) & alu_done;

  always_comb begin
    state_nxt   = state_r;
    mpc_nxt     = mpc_r;
    step_nxt    = step_r;
    cmd_nxt     = cmd_r;
    last_nxt    = last_r;
    illegal_nxt = illegal_r;
    init_nxt    = init_r;
    run_nxt     = run_r;
    err_nxt     = err_r;
    ovalid_nxt  = ovalid_r & ~out_tready;
    ox_nxt      = ox_r;
    oz_nxt      = oz_r;
    obad_nxt    = obad_r;
    opa_nxt     = opa_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_tdata[3:0];
          last_nxt    = in_tlast;
          illegal_nxt = cmd_bad;
          run_nxt     = 1'b1;
          err_nxt     = (run_r & err_r) | cmd_bad;
          step_nxt    = '0;
          priority if (!run_r) begin
            mpc_nxt   = INIT_IDX;
            init_nxt  = 1'b1;
            state_nxt = S_FETCH;
          end else if (cmd_bad) begin
            state_nxt = S_FIN;
          end else begin
            mpc_nxt   = op_start(in_tdata[3:0]);
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: state_nxt = S_RDA;
      S_RDA: begin
        opa_nxt   = src_val(uop.srca, rdata, cb_r, sx_r, sz_r);
        state_nxt = S_RDB;
      end
      S_RDB: state_nxt = S_EXEC;
      S_EXEC: begin
        if (alu_done) begin
          state_nxt = S_FETCH;
          if (!uop.last) begin
            step_nxt = step_r + 1'b1;
          end else begin
            step_nxt = '0;
            if (!mac.fin) begin
              mpc_nxt = mpc_r + 1'b1;
            end else if (init_r && !illegal_r) begin
              init_nxt = 1'b0;
              mpc_nxt  = op_start(cmd_r);
            end else begin
              init_nxt  = 1'b0;
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = ax_r;
          oz_nxt     = az_r;
          obad_nxt   = err_r;
          run_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mpc_r     <= '0;
      step_r    <= '0;
      init_r    <= 1'b0;
      run_r     <= 1'b0;
      err_r     <= 1'b0;
      ovalid_r  <= 1'b0;
      illegal_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mpc_r     <= mpc_nxt;
      step_r    <= step_nxt;
      init_r    <= init_nxt;
      run_r     <= run_nxt;
      err_r     <= err_nxt;
      ovalid_r  <= ovalid_nxt;
      illegal_r <= illegal_nxt;
      last_r    <= last_nxt;
    end
    cmd_r  <= cmd_nxt;
    ox_r   <= ox_nxt;
    oz_r   <= oz_nxt;
    obad_r <= obad_nxt;
    opa_r  <= opa_nxt;
  end

  // shadow copy of A for the result transaction
  always_ff @(posedge clk) begin
    if (we && {1'b0, uop.dst} == sx(PT_A)) ax_r <= alu_res;
    if (we && {1'b0, uop.dst} == sz(PT_A)) az_r <= alu_res;
  end

  ecmsc_ram #(
    .WIDTH(W),
    .DEPTH(16)
  ) u_regfile (
    .clk  (clk),
    .we   (we),
    .waddr(uop.dst),
    .wdata(alu_res),
    .raddr(raddr),
    .rdata(rdata)
  );

  ecmsc_alu #(
    .W(W)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .op    (uop.op),
    .a     (opa_r),
    .b     (opb),
    .m     (mod_r[W-1:0]),
    .done  (alu_done),
    .result(alu_res)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {64'(oz_r), 64'(ox_r)};
  assign out_tuser  = obad_r;

endmodule

>>> verif/testbench.sv
// Testbench for ecm_stage1_chain_interpreter_core: chain opcodes go in, A's x:z comes out.
// A predictor of the point arithmetic computes each expected result.
// Depends on design/ecmsc_pkg.sv and the core module.
module testbench;
  import ecmsc_pkg::*;

  // chain opcodes
  localparam logic [3:0] CMD_SWAP_AB   = 4'd0;
  localparam logic [3:0] CMD_TRIPLE    = 4'd1;
  localparam logic [3:0] CMD_ADD_DBL   = 4'd2;
  localparam logic [3:0] CMD_ADD_ROT   = 4'd3;
  localparam logic [3:0] CMD_BADD_DBL  = 4'd4;
  localparam logic [3:0] CMD_CADD_DBL  = 4'd5;
  localparam logic [3:0] CMD_MIX6      = 4'd6;
  localparam logic [3:0] CMD_MIX7      = 4'd7;
  localparam logic [3:0] CMD_MIX8      = 4'd8;
  localparam logic [3:0] CMD_CB_BDBL   = 4'd9;
  localparam logic [3:0] CMD_COPY_DBL  = 4'd10;
  localparam logic [3:0] CMD_ADD_ONLY  = 4'd11;
  localparam logic [3:0] CMD_DBL_ONLY  = 4'd12;
  localparam logic [3:0] CMD_ILLEGAL_A = 4'd13;
  localparam logic [3:0] CMD_ILLEGAL_C = 4'd15;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE      = 200;

  typedef struct {
    logic [63:0] x;
    logic [63:0] z;
  } xz_t;

  typedef struct {
    logic [63:0] x;
    logic [63:0] z;
    logic        bad;
  } point_out_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  ecm_stage1_chain_interpreter_core u_top (.*);

  // predictor state
  logic [63:0] modulus_q, curve_b_q, start_x_q, start_z_q;
  xz_t         pa, pb, pc, pt1, pt2;
  logic        in_run, bad_seen;
  point_out_t  expected_points[$];

  int  fail_count;
  int  cycle_count;
  int  burst_left;
  bit  long_hold;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] m_red(input logic [63:0] a);
    return (modulus_q == 0) ? 64'd0 : a % modulus_q;
  endfunction

  function automatic logic [63:0] m_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, m_red(a)} + {1'b0, m_red(b)};
    if (s >= {1'b0, modulus_q}) s = s - {1'b0, modulus_q};
    return s[63:0];
  endfunction

  function automatic logic [63:0] m_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ra, rb;
    ra = m_red(a);
    rb = m_red(b);
    return (ra >= rb) ? ra - rb : ra + (modulus_q - rb);
  endfunction

  function automatic logic [63:0] m_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    if (modulus_q == 0) return 64'd0;
    p = {64'd0, m_red(a)} * {64'd0, m_red(b)};
    p = p % {64'd0, modulus_q};
    return p[63:0];
  endfunction

  function automatic xz_t pt_double(input xz_t p);
    xz_t q;
    logic [63:0] u, v, w;
    u = m_mul(m_add(p.x, p.z), m_add(p.x, p.z));
    v = m_mul(m_sub(p.x, p.z), m_sub(p.x, p.z));
    q.x = m_mul(u, v);
    w = m_sub(u, v);
    q.z = m_mul(w, m_add(m_mul(w, curve_b_q), v));
    return q;
  endfunction

  // p+q with difference d
  function automatic xz_t pt_diff_add(input xz_t p, input xz_t q, input xz_t d);
    xz_t r;
    logic [63:0] u, v, w;
    u = m_mul(m_sub(p.x, p.z), m_add(q.x, q.z));
    v = m_mul(m_add(p.x, p.z), m_sub(q.x, q.z));
    w = m_add(u, v);
    v = m_sub(u, v);
    w = m_mul(w, w);
    v = m_mul(v, v);
    r.x = m_mul(w, d.z);
    r.z = m_mul(d.x, v);
    return r;
  endfunction

  task automatic apply_chain_cmd(input logic [3:0] cmd, input logic fin);
    xz_t s, zero_pt;
    point_out_t res;
    zero_pt.x = 0;
    zero_pt.z = 0;
    if (!in_run) begin
      pa.x = m_red(start_x_q);
      pa.z = m_red(start_z_q);
      pb = zero_pt;
      pc = zero_pt;
      pt1 = zero_pt;
      pt2 = zero_pt;
      bad_seen = 1'b0;
      in_run = 1'b1;
    end
    case (cmd)
      CMD_SWAP_AB: begin s = pa; pa = pb; pb = s; end
      CMD_TRIPLE: begin
        pt1 = pt_diff_add(pa, pb, pc);
        pt2 = pt_diff_add(pt1, pa, pb);
        pb = pt_diff_add(pb, pt1, pa);
        pa = pt2;
      end
      CMD_ADD_DBL: begin pb = pt_diff_add(pa, pb, pc); pa = pt_double(pa); end
      CMD_ADD_ROT: begin pc = pt_diff_add(pb, pa, pc); s = pb; pb = pc; pc = s; end
      CMD_BADD_DBL: begin pb = pt_diff_add(pb, pa, pc); pa = pt_double(pa); end
      CMD_CADD_DBL: begin pc = pt_diff_add(pc, pa, pb); pa = pt_double(pa); end
      CMD_MIX6: begin
        pt1 = pt_double(pa);
        pt2 = pt_diff_add(pa, pb, pc);
        pa = pt_diff_add(pt1, pa, pa);
        pc = pt_diff_add(pt1, pt2, pc);
        s = pb; pb = pc; pc = s;
      end
      CMD_MIX7: begin
        pt1 = pt_diff_add(pa, pb, pc);
        pb = pt_diff_add(pt1, pa, pb);
        pt1 = pt_double(pa);
        pa = pt_diff_add(pa, pt1, pa);
      end
      CMD_MIX8: begin
        pt1 = pt_diff_add(pa, pb, pc);
        pc = pt_diff_add(pc, pa, pb);
        pb = pt1;
        pt1 = pt_double(pa);
        pa = pt_diff_add(pa, pt1, pa);
      end
      CMD_CB_BDBL: begin pc = pt_diff_add(pc, pb, pa); pb = pt_double(pb); end
      CMD_COPY_DBL: begin pb = pa; pc = pa; pa = pt_double(pa); end
      CMD_ADD_ONLY: pa = pt_diff_add(pa, pb, pc);
      CMD_DBL_ONLY: pa = pt_double(pa);
      default: bad_seen = 1'b1;
    endcase
    if (fin) begin
      res.x = pa.x;
      res.z = pa.z;
      res.bad = bad_seen;
      expected_points.push_back(res);
      in_run = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- clock, limits
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n || long_hold) begin
      out_tready <= 1'b0;
    end else if ((cycle_count % 97) < 40) begin
      out_tready <= 1'b1;   // unstalled stretch
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    point_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%h z=%h bad=%b", $time,
                 out_tdata[63:0], out_tdata[127:64], out_tuser);
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (out_tdata[63:0] !== e.x) begin
          $display("%0t: point_x expected %h actual %h", $time, e.x, out_tdata[63:0]);
          fail_count++;
        end
        if (out_tdata[127:64] !== e.z) begin
          $display("%0t: point_z expected %h actual %h", $time, e.z, out_tdata[127:64]);
          fail_count++;
        end
        if (out_tuser !== e.bad) begin
          $display("%0t: bad_opcode expected %b actual %b", $time, e.bad, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_cmd(input logic [3:0] cmd, input logic fin);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, cmd};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_chain_cmd(cmd, fin);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'd0};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODULUS: modulus_q = value;
      REG_CURVE_B: curve_b_q = value;
      REG_START_X: start_x_q = value;
      default:     start_z_q = value;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_curve(input logic [63:0] m, input logic [63:0] b,
                           input logic [63:0] x, input logic [63:0] z);
    drain_results();
    cfg_write(REG_MODULUS, m);
    cfg_write(REG_CURVE_B, b);
    cfg_write(REG_START_X, x);
    cfg_write(REG_START_Z, z);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly cheap opcodes, the long ones now and then
  function automatic logic [3:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 4'($urandom_range(CMD_TRIPLE, CMD_MIX8));
    if (r < 16) return 4'($urandom_range(CMD_ILLEGAL_A, CMD_ILLEGAL_C));
    case ($urandom_range(0, 5))
      0: return CMD_SWAP_AB;
      1: return CMD_ADD_ROT;
      2: return CMD_COPY_DBL;
      3: return CMD_ADD_ONLY;
      4: return CMD_CB_BDBL;
      default: return CMD_DBL_ONLY;
    endcase
  endfunction

  task automatic random_runs(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) send_cmd(pick_cmd(), i == len - 1);
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    send_cmd(CMD_DBL_ONLY, 1'b1);
    send_cmd(CMD_COPY_DBL, 1'b0);
    send_cmd(CMD_ADD_ONLY, 1'b1);
  endtask

  task automatic test_each_opcode();
    set_curve(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
              64'd0);
    send_cmd(CMD_COPY_DBL, 1'b1);
    set_curve(64'hFFFF_FFFF_FFFF_FFC5, 64'h1234_5678_9ABC_DEF1, 64'hFFFF_FFFF_FFFF_FFFE, 64'd7);
    send_cmd(CMD_COPY_DBL, 1'b0);
    for (int c = 0; c < 16; c++) send_cmd(4'(c), c == 12 || c == 15);
    send_cmd(CMD_ILLEGAL_A, 1'b1);
  endtask

  task automatic test_random_curves();
    logic [63:0] m;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: m = 64'd3;
        1: m = 64'd5;
        2: m = 64'd4;   // even modulus, results still checked
        3: m = 64'hFFFF_FFFF_FFFF_FFFF;
        default: m = rand64() | 64'd1;
      endcase
      set_curve(m, rand64(), rand64(), (ph == 4) ? 64'd1 : rand64());
      random_runs(170);
    end
  endtask

  task automatic test_output_stall();
    set_curve(rand64() | 64'h8000_0000_0000_0001, rand64(), rand64(), rand64());
    fork
      begin
        long_hold = 1'b1;
        repeat (20000) @(posedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_cmd(CMD_SWAP_AB, 1'b1);
    join
    random_runs(60);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 5'd0;
    cfg_pwdata  = 64'd0;
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = 0;
    long_hold   = 1'b0;
    modulus_q   = 64'd3;
    curve_b_q   = 64'd0;
    start_x_q   = 64'd0;
    start_z_q   = 64'd1;
    in_run      = 1'b0;
    bad_seen    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_each_opcode();
    test_output_stall();
    test_random_curves();
    drain_results();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/ecmsc_pkg.sv
design/ecmsc_ram.sv
design/ecmsc_alu.sv
design/ecm_stage1_chain_interpreter_core.sv
verif/testbench.sv
